>>> hdl/gsds_pkg.sv
// ----------------------------------------------------------------------------
// Grid stencil dose sweep package
// Shared constants, register indexes and stage bundles for the sweep block.
// ----------------------------------------------------------------------------
package gsds_pkg;

   localparam int MAX_COLS_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT = 1024;

   localparam int CELL_W     = 16;
   localparam int COUNT_W    = 11;
   localparam int DOSE_W     = 15;
   localparam int SUM_W      = 52;
   localparam int SQUARE_W   = 2 * CELL_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam int MIN_COUNT   = 3;
   localparam int QUEUE_DEPTH = 8;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
   localparam logic [DOSE_W-1:0]  DOSE_RESET  = '0;
   localparam logic [CELL_W-1:0]  AVG_HIGH    = 16'd200;
   localparam logic [CELL_W-1:0]  AVG_LOW     = 16'd100;
   localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMN_COUNT = 2'd0,
      CSR_ROW_COUNT    = 2'd1,
      CSR_DOSE         = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic boundary;
      logic special;
      logic emit_a;
      logic emit_b;
      logic last;
   } ctl_type;

   typedef struct packed {
      logic              valid;
      ctl_type           ctl;
      logic [CELL_W-1:0] x;
      logic [CELL_W-1:0] above;
      logic [CELL_W-1:0] left;
      logic [CELL_W-1:0] center;
      logic [CELL_W-1:0] right;
   } tap_type;

   typedef struct packed {
      logic              valid;
      logic              emit_a;
      logic              emit_b;
      logic              last;
      logic [CELL_W-1:0] cell_a;
      logic [CELL_W-1:0] cell_b;
   } pair_type;

   typedef struct packed {
      logic              emit_a;
      logic              emit_b;
      logic              last;
      logic [CELL_W-1:0] cell_a;
      logic [CELL_W-1:0] cell_b;
      logic [SUM_W-1:0]  square_sum;
   } entry_type;

   typedef struct packed {
      logic      valid;
      logic      drop;
      entry_type entry;
   } push_type;

endpackage

>>> hdl/gsds_ram.sv
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with a registered read. A read and a
// write of the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module gsds_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/gsds_front.sv
// ----------------------------------------------------------------------------
// Sweep front end
// Tracks the raster position, keeps the two most recent rows in two RAM
// banks and assembles the four neighbors and the old value of each cell.
// ----------------------------------------------------------------------------
module gsds_front #(
   parameter int MAX_COLS = gsds_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = gsds_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [gsds_pkg::CELL_W-1:0]    cell_in,
   input  logic [gsds_pkg::COUNT_W-1:0]   column_count,
   input  logic [gsds_pkg::COUNT_W-1:0]   row_count,
   output gsds_pkg::tap_type              taps
);

   import gsds_pkg::*;

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CCW = (CW + 1 > COUNT_W) ? CW + 1 : COUNT_W;
   localparam int RCW = (RW + 1 > COUNT_W) ? RW + 1 : COUNT_W;

   logic [CW-1:0]  col_ff;
   logic [CW-1:0]  col_in;
   logic [RW-1:0]  row_ff;
   logic [RW-1:0]  row_in;
   logic [CCW-1:0] cols_raw;
   logic [CCW-1:0] cols;
   logic [RCW-1:0] rows_raw;
   logic [RCW-1:0] rows;
   logic           last_col;
   logic           last_row;
   ctl_type        ctl;

   logic [CELL_W-1:0] bank_rd [2];

   logic              s1_valid_ff;
   ctl_type           s1_ctl_ff;
   logic [CELL_W-1:0] s1_x_ff;
   logic              s1_parity_ff;
   logic              s1_first_ff;
   logic [CELL_W-1:0] win_left_ff;
   logic [CELL_W-1:0] win_center_ff;
   logic [CELL_W-1:0] col0_ff;
   logic [CELL_W-1:0] center;
   logic [CELL_W-1:0] prev_rd;
   logic [CELL_W-1:0] cur_rd;

   always_comb begin
      cols_raw = CCW'(column_count);
      rows_raw = RCW'(row_count);
      if (cols_raw < CCW'(MIN_COUNT)) begin
         cols = CCW'(MIN_COUNT);
      end else if (cols_raw > CCW'(MAX_COLS)) begin
         cols = CCW'(MAX_COLS);
      end else begin
         cols = cols_raw;
      end
      if (rows_raw < RCW'(MIN_COUNT)) begin
         rows = RCW'(MIN_COUNT);
      end else if (rows_raw > RCW'(MAX_ROWS)) begin
         rows = RCW'(MAX_ROWS);
      end else begin
         rows = rows_raw;
      end

      last_col = CCW'(col_ff) >= (cols - CCW'(1));
      last_row = RCW'(row_ff) >= (rows - RCW'(1));

      ctl.boundary = (row_ff == RW'(1)) || (RCW'(row_ff) >= rows) ||
                     (col_ff == '0) || last_col;
      ctl.special  = row_ff[0] && !col_ff[0];
      ctl.emit_a   = (row_ff != '0);
      ctl.emit_b   = last_row;
      ctl.last     = last_row && last_col;

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Bank b holds the rows whose index has parity b. The current bank is
   // read at this column (two rows up) and the other bank one column ahead.
   for (genvar b = 0; b < 2; b++) begin : g_bank
      logic          is_cur;
      logic [CW-1:0] rd_addr;

      assign is_cur  = (row_ff[0] == 1'(b));
      assign rd_addr = is_cur ? col_ff : col_ff + CW'(1);

      gsds_ram #(
         .WIDTH (CELL_W),
         .DEPTH (MAX_COLS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (accept && is_cur),
         .wr_addr (col_ff),
         .wr_data (cell_in),
         .rd_en   (accept),
         .rd_addr (rd_addr),
         .rd_data (bank_rd[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff    <= ctl;
         s1_x_ff      <= cell_in;
         s1_parity_ff <= row_ff[0];
         s1_first_ff  <= (col_ff == '0);
      end
   end

   always_comb begin
      cur_rd  = s1_parity_ff ? bank_rd[1] : bank_rd[0];
      prev_rd = s1_parity_ff ? bank_rd[0] : bank_rd[1];
      center  = s1_first_ff ? col0_ff : win_center_ff;
   end

   // The first column of the row above is kept aside because its read
   // slot is taken by the last column of the previous row.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_left_ff   <= center;
         win_center_ff <= prev_rd;
         if (s1_first_ff) begin
            col0_ff <= s1_x_ff;
         end
      end
   end

   always_comb begin
      taps.valid  = s1_valid_ff;
      taps.ctl    = s1_ctl_ff;
      taps.x      = s1_x_ff;
      taps.above  = cur_rd;
      taps.left   = win_left_ff;
      taps.center = center;
      taps.right  = prev_rd;
   end

endmodule

>>> hdl/gsds_stencil.sv
// ----------------------------------------------------------------------------
// Stencil and dose arithmetic
// Averages the four neighbors, applies the dose step on even positions,
// saturates and forms the result pair of one input cell.
// ----------------------------------------------------------------------------
module gsds_stencil (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [gsds_pkg::DOSE_W-1:0] dose,
   input  gsds_pkg::tap_type           taps,
   output gsds_pkg::pair_type          pair
);

   import gsds_pkg::*;

   logic [CELL_W+1:0]   sum;
   logic [CELL_W-1:0]   avg;
   logic signed [17:0]  dose_ext;
   logic signed [17:0]  dose_x3;
   logic signed [17:0]  dose_x4;
   logic signed [17:0]  dose_x5;
   logic signed [17:0]  dose_k;
   logic signed [18:0]  dosed;

   logic                s2_valid_ff;
   ctl_type             s2_ctl_ff;
   logic [CELL_W-1:0]   s2_avg_ff;
   logic [CELL_W-1:0]   s2_old_ff;
   logic [CELL_W-1:0]   s2_x_ff;
   logic signed [18:0]  s2_dosed_ff;

   logic [18:0]         mag;
   logic [CELL_W-1:0]   mag_sat;
   logic [CELL_W-1:0]   cell_new;

   logic                s3_valid_ff;
   logic                s3_emit_a_ff;
   logic                s3_emit_b_ff;
   logic                s3_last_ff;
   logic [CELL_W-1:0]   s3_cell_a_ff;
   logic [CELL_W-1:0]   s3_cell_b_ff;

   always_comb begin
      sum = (CELL_W + 2)'(taps.above) + (CELL_W + 2)'(taps.left) +
            (CELL_W + 2)'(taps.right) + (CELL_W + 2)'(taps.x);
      avg = sum[CELL_W+1:2];

      dose_ext = $signed({{3{dose[DOSE_W-1]}}, dose});
      dose_x3  = dose_ext + (dose_ext <<< 1);
      dose_x4  = dose_ext <<< 2;
      dose_x5  = dose_ext + (dose_ext <<< 2);

      if (avg == AVG_HIGH) begin
         dose_k = dose_x4;
      end else if (avg == AVG_LOW) begin
         dose_k = dose_x3;
      end else begin
         dose_k = dose_x5;
      end
      dosed = $signed({dose_k[17], dose_k}) + $signed({3'b000, taps.center});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= taps.valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_ctl_ff   <= taps.ctl;
      s2_avg_ff   <= avg;
      s2_old_ff   <= taps.center;
      s2_x_ff     <= taps.x;
      s2_dosed_ff <= dosed;
   end

   always_comb begin
      mag     = s2_dosed_ff[18] ? 19'(-s2_dosed_ff) : 19'(s2_dosed_ff);
      mag_sat = (mag[18:CELL_W] != '0) ? {CELL_W{1'b1}} : mag[CELL_W-1:0];
      if (s2_ctl_ff.boundary) begin
         cell_new = s2_old_ff;
      end else if (s2_ctl_ff.special) begin
         cell_new = mag_sat;
      end else begin
         cell_new = s2_avg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_emit_a_ff <= s2_ctl_ff.emit_a;
      s3_emit_b_ff <= s2_ctl_ff.emit_b;
      s3_last_ff   <= s2_ctl_ff.last;
      s3_cell_a_ff <= cell_new;
      s3_cell_b_ff <= s2_x_ff;
   end

   always_comb begin
      pair.valid  = s3_valid_ff;
      pair.emit_a = s3_emit_a_ff;
      pair.emit_b = s3_emit_b_ff;
      pair.last   = s3_last_ff;
      pair.cell_a = s3_cell_a_ff;
      pair.cell_b = s3_cell_b_ff;
   end

endmodule

>>> hdl/gsds_accum.sv
// ----------------------------------------------------------------------------
// Square-sum accumulator
// Squares the results of each input cell, adds them to the saturating sweep
// total and hands the finished entry to the output queue.
// ----------------------------------------------------------------------------
module gsds_accum (
   input  logic               clock,
   input  logic               reset,
   input  gsds_pkg::pair_type pair,
   output gsds_pkg::push_type push
);

   import gsds_pkg::*;

   logic                s4_valid_ff;
   pair_type            s4_pair_ff;
   logic [SQUARE_W-1:0] s4_sq_a_ff;
   logic [SQUARE_W-1:0] s4_sq_b_ff;

   logic                s5_valid_ff;
   pair_type            s5_pair_ff;
   logic [SQUARE_W:0]   s5_sq_ff;

   logic [SUM_W-1:0]    acc_ff;
   logic [SUM_W-1:0]    acc_in;
   logic [SUM_W:0]      total_raw;
   logic [SUM_W-1:0]    total;
   logic                any_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= pair.valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_pair_ff <= pair;
      s4_sq_a_ff <= pair.emit_a ? SQUARE_W'(pair.cell_a) * SQUARE_W'(pair.cell_a) : '0;
      s4_sq_b_ff <= pair.emit_b ? SQUARE_W'(pair.cell_b) * SQUARE_W'(pair.cell_b) : '0;
      s5_pair_ff <= s4_pair_ff;
      s5_sq_ff   <= (SQUARE_W + 1)'(s4_sq_a_ff) + (SQUARE_W + 1)'(s4_sq_b_ff);
   end

   // Both squares of one cell are added at once; saturation of the sum
   // equals saturating after each of them since all terms are positive.
   always_comb begin
      any_result = s5_pair_ff.emit_a || s5_pair_ff.emit_b;
      total_raw  = (SUM_W + 1)'(acc_ff) + (SUM_W + 1)'(s5_sq_ff);
      total      = total_raw[SUM_W] ? SUM_MAX : total_raw[SUM_W-1:0];
      acc_in     = s5_pair_ff.last ? '0 : total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (s5_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      push.valid            = s5_valid_ff && any_result;
      push.drop             = s5_valid_ff && !any_result;
      push.entry.emit_a     = s5_pair_ff.emit_a;
      push.entry.emit_b     = s5_pair_ff.emit_b;
      push.entry.last       = s5_pair_ff.last;
      push.entry.cell_a     = s5_pair_ff.cell_a;
      push.entry.cell_b     = s5_pair_ff.cell_b;
      push.entry.square_sum = total;
   end

endmodule

>>> hdl/gsds_out_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Holds the result pairs of finished cells and sends them out one beat per
// result, the new cell first and the flushed last-row cell second.
// ----------------------------------------------------------------------------
module gsds_out_queue #(
   parameter int DEPTH = gsds_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gsds_pkg::push_type          push,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gsds_pkg::CELL_W-1:0] rsp_cell_out,
   output logic                        rsp_last_cell,
   output logic [gsds_pkg::SUM_W-1:0]  rsp_square_sum
);

   import gsds_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   entry_type      mem_ff [DEPTH];
   logic [PW-1:0]  head_ff;
   logic [PW-1:0]  tail_ff;
   logic [NW-1:0]  count_ff;
   logic           phase_ff;
   logic           phase_in;
   entry_type      head;
   logic           sel_b;
   logic           beat;
   logic           final_beat;

   always_comb begin
      head           = mem_ff[head_ff];
      sel_b          = !head.emit_a || phase_ff;
      rsp_valid      = (count_ff != '0);
      rsp_cell_out   = sel_b ? head.cell_b : head.cell_a;
      rsp_last_cell  = sel_b && head.last;
      rsp_square_sum = (sel_b && head.last) ? head.square_sum : '0;
      beat           = rsp_valid && rsp_ready;
      final_beat     = sel_b || !head.emit_b;
      pop            = beat && final_beat;
      if (beat) begin
         phase_in = !final_beat;
      end else begin
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[tail_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (push.valid) begin
            tail_ff <= (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);
         end
         if (pop) begin
            head_ff <= (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
         end
         count_ff <= count_ff + NW'(push.valid) - NW'(pop);
      end
   end

endmodule

>>> hdl/grid_stencil_dose_sweep_top.sv
// ----------------------------------------------------------------------------
// Grid stencil dose sweep, top level
// Streams the old grid in raster order and returns the new grid one row
// behind, with a Jacobi four-point average, a dose step on even positions
// and a saturating sum of squares on the final cell.
//
// The req_ channel takes one old cell per beat and the rsp_ channel gives
// one new cell per beat; both use valid and ready. Rows other than the
// first give one result beat per input cell, and cells of the last row give
// two: the new cell of the row above, then the cell itself.
// A result beat is offered once its input beat has passed stages s1 to s5
// and been written to the queue. The block takes one input beat per cycle
// while req_ready is high; on the last row the output needs two beats per
// input, so req_ready holds the input back there.
// Finished results wait in an eight-entry queue; req_ready drops only when
// eight input cells are in flight or queued, so a stalled receiver backs
// up the input after that and nothing is lost.
// Write column_count, row_count and dose via the csr_ port only while the
// block is idle; it does not enforce this. Reset clears positions, the sum
// and queue and restores the defaults; row buffers are not cleared, nor need be.
// ----------------------------------------------------------------------------
module grid_stencil_dose_sweep_top #(
   parameter int MAX_COLS = gsds_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = gsds_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gsds_pkg::CELL_W-1:0]     req_cell_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gsds_pkg::CELL_W-1:0]     rsp_cell_out,
   output logic                            rsp_last_cell,
   output logic [gsds_pkg::SUM_W-1:0]      rsp_square_sum,
   input  logic                            csr_wr_en,
   input  logic [gsds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gsds_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import gsds_pkg::*;

   localparam int OW = $clog2(QUEUE_DEPTH + 1);

   logic [COUNT_W-1:0] column_count_ff;
   logic [COUNT_W-1:0] row_count_ff;
   logic [DOSE_W-1:0]  dose_ff;
   logic [OW-1:0]      occ_ff;
   logic [OW-1:0]      occ_in;
   logic               accept;
   logic               pop;
   tap_type            taps;
   pair_type           pair;
   push_type           push;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COUNT_RESET;
         row_count_ff    <= COUNT_RESET;
         dose_ff         <= DOSE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_COLUMN_COUNT: column_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[COUNT_W-1:0];
            CSR_DOSE:         dose_ff         <= csr_wdata[DOSE_W-1:0];
            default: ;
         endcase
      end
   end

   // Every input cell holds a queue slot from acceptance until its results
   // have left, so the queue can never overflow.
   always_comb begin
      req_ready = (occ_ff < OW'(QUEUE_DEPTH));
      accept    = req_valid && req_ready;
      occ_in    = occ_ff + OW'(accept) - OW'(push.drop) - OW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   gsds_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cell_in      (req_cell_in),
      .column_count (column_count_ff),
      .row_count    (row_count_ff),
      .taps         (taps)
   );

   gsds_stencil u_stencil (
      .clock (clock),
      .reset (reset),
      .dose  (dose_ff),
      .taps  (taps),
      .pair  (pair)
   );

   gsds_accum u_accum (
      .clock (clock),
      .reset (reset),
      .pair  (pair),
      .push  (push)
   );

   gsds_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_out   (rsp_cell_out),
      .rsp_last_cell  (rsp_last_cell),
      .rsp_square_sum (rsp_square_sum)
   );

endmodule

>>> bench/grid_stencil_dose_sweep_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid stencil dose sweep testbench
// Streams old grids through the block and checks every new cell, the final
// cell flag and the sum of squares against an in-bench stencil predictor.
// A short hand-built grid hits both special dose factors, the saturation of the
// dose step and its absolute value. Random sweeps follow, some with counts
// out of range and some with counts cut short in the middle of a sweep.
// The sender works in bursts with gaps and the receiver stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module grid_stencil_dose_sweep_top_tb;
   import gsds_pkg::*;

   localparam int GRID_MAX      = MAX_COLS_DEFAULT;
   localparam int ROW_MAX       = MAX_ROWS_DEFAULT;
   localparam int CELL_LIMIT    = (1 << CELL_W) - 1;
   localparam int DRAIN_CYCLES  = 24;
   localparam int RANDOM_CELLS  = 600;
   localparam int PRINT_LIMIT   = 40;

   typedef struct {
      logic [CELL_W-1:0] new_value;
      logic              is_last;
      logic [SUM_W-1:0]  square_sum;
   } new_cell_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN,
      READY_SPARSE
   } ready_mode_type;

   typedef enum logic [1:0] {
      SWEEP_PLAIN,
      SWEEP_ROWS_CUT,
      SWEEP_COLS_CUT
   } sweep_kind_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [CELL_W-1:0]     req_cell_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [CELL_W-1:0]     rsp_cell_out;
   logic                  rsp_last_cell;
   logic [SUM_W-1:0]      rsp_square_sum;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   logic [CELL_W-1:0]        old_row_buffer [0:2*GRID_MAX-1];
   int                       sweep_col     = 0;
   int                       sweep_row     = 0;
   logic [SUM_W-1:0]         square_total  = '0;
   logic [COUNT_W-1:0]       cols_setting  = COUNT_RESET;
   logic [COUNT_W-1:0]       rows_setting  = COUNT_RESET;
   logic signed [DOSE_W-1:0] dose_setting  = DOSE_RESET;

   new_cell_type      expected_cells [$];
   logic [CELL_W-1:0] old_cells_to_send [$];
   int                cells_queued   = 0;
   int                mismatch_count = 0;

   int                burst_left    = 1;
   int                gap_left      = 0;
   int                stall_count   = 0;
   ready_mode_type    stall_mode    = READY_ALWAYS;
   logic [7:0]        stall_pattern = 8'hB5;

   grid_stencil_dose_sweep_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cell_in    (req_cell_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_out   (rsp_cell_out),
      .rsp_last_cell  (rsp_last_cell),
      .rsp_square_sum (rsp_square_sum),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int clamp_count(logic [COUNT_W-1:0] value, int hi);
      if (int'(value) < MIN_COUNT) return MIN_COUNT;
      if (int'(value) > hi) return hi;
      return int'(value);
   endfunction

   function automatic void push_new_cell(logic [CELL_W-1:0] value, logic is_last);
      new_cell_type    entry;
      longint unsigned total;
      longint unsigned square;
      square = 64'(value);
      square = square * square;
      total  = 64'(square_total) + square;
      if (total > 64'(SUM_MAX)) total = 64'(SUM_MAX);
      square_total     = total[SUM_W-1:0];
      entry.new_value  = value;
      entry.is_last    = is_last;
      entry.square_sum = is_last ? square_total : '0;
      expected_cells.push_back(entry);
   endfunction

   function automatic void predict_new_cells(logic [CELL_W-1:0] x);
      int                cols;
      int                rows;
      int                c;
      int                r;
      int                cur;
      int                prev;
      int                orow;
      int                avg;
      int                k;
      int                t;
      int                dose_val;
      logic [CELL_W-1:0] old;
      logic [CELL_W-1:0] v;
      logic              last_col;
      logic              last_row;
      cols = clamp_count(cols_setting, GRID_MAX);
      rows = clamp_count(rows_setting, ROW_MAX);
      c    = sweep_col;
      r    = sweep_row;
      if (c >= GRID_MAX) c = GRID_MAX - 1;
      last_col = (c >= cols - 1);
      last_row = (r >= rows - 1);
      cur      = (r % 2) * GRID_MAX;
      if (r >= 1) begin
         prev = ((r - 1) % 2) * GRID_MAX;
         orow = r - 1;
         old  = old_row_buffer[prev + c];
         if (orow == 0 || orow >= rows - 1 || c == 0 || last_col) begin
            v = old;
         end else begin
            avg = (int'(old_row_buffer[cur + c]) + int'(old_row_buffer[prev + c - 1]) +
                   int'(old_row_buffer[prev + c + 1]) + int'(x)) >> 2;
            v = avg[CELL_W-1:0];
            if (orow % 2 == 0 && c % 2 == 0) begin
               k        = (avg == int'(AVG_HIGH)) ? 4 : (avg == int'(AVG_LOW)) ? 3 : 5;
               dose_val = int'(dose_setting);
               t        = k * dose_val + int'(old);
               if (t < 0) t = -t;
               v = (t > CELL_LIMIT) ? '1 : t[CELL_W-1:0];
            end
         end
         push_new_cell(v, 1'b0);
      end
      old_row_buffer[cur + c] = x;
      if (last_row) push_new_cell(x, last_col);
      if (last_col) begin
         sweep_col = 0;
         if (last_row) begin
            sweep_row    = 0;
            square_total = '0;
         end else begin
            sweep_row = r + 1;
         end
      end else begin
         sweep_col = c + 1;
      end
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (old_cells_to_send.size() > 0) begin
            req_valid   <= 1'b1;
            req_cell_in <= old_cells_to_send.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      stall_count++;
      if (stall_count >= 150) begin
         stall_count   = 0;
         stall_mode    = ready_mode_type'($urandom_range(0, 3));
         stall_pattern = 8'($urandom_range(1, 255));
      end
      case (stall_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_RANDOM: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         READY_PATTERN: begin
            rsp_ready <= stall_pattern[stall_count % 8];
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      new_cell_type want;
      if (!reset) begin
         if (req_valid && req_ready) predict_new_cells(req_cell_in);
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               report_mismatch("unexpected result beat, cell_out", rsp_cell_out, 0);
            end else begin
               want = expected_cells.pop_front();
               if (rsp_cell_out !== want.new_value)
                  report_mismatch("cell_out", rsp_cell_out, want.new_value);
               if (rsp_last_cell !== want.is_last)
                  report_mismatch("last_cell", rsp_last_cell, want.is_last);
               if (rsp_square_sum !== want.square_sum)
                  report_mismatch("square_sum", rsp_square_sum, want.square_sum);
            end
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_COLUMN_COUNT: begin
            cols_setting = value[COUNT_W-1:0];
         end
         CSR_ROW_COUNT: begin
            rows_setting = value[COUNT_W-1:0];
         end
         CSR_DOSE: begin
            dose_setting = value[DOSE_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic write_count(csr_index_type idx, int value);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);
      word[COUNT_W-1:0] = value[COUNT_W-1:0];
      write_reg(idx, word);
   endtask

   function automatic logic [CELL_W-1:0] pick_cell();
      case ($urandom_range(0, 9))
         0, 1, 2: return AVG_HIGH;
         3, 4:    return AVG_LOW;
         5:       return '0;
         6:       return '1;
         7:       return CELL_W'($urandom_range(96, 204));
         default: return CELL_W'($urandom_range(0, CELL_LIMIT));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dose();
      int small_dose;
      case ($urandom_range(0, 5))
         0: return 15'h4000;
         1: return 15'h3FFF;
         2: return '0;
         3: begin
            small_dose = $urandom_range(0, 400);
            small_dose = small_dose - 200;
            return small_dose[CSR_DATA_W-1:0];
         end
         default: return CSR_DATA_W'($urandom_range(0, 32767));
      endcase
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (old_cells_to_send.size() != 0 || req_valid || expected_cells.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_cells(int count);
      @(negedge clock);
      repeat (count) old_cells_to_send.push_back(pick_cell());
      cells_queued += count;
   endtask

   task automatic finish_sweep();
      int cols;
      int rows;
      int row_rest;
      int total;
      cols     = clamp_count(cols_setting, GRID_MAX);
      rows     = clamp_count(rows_setting, ROW_MAX);
      row_rest = (sweep_col >= cols - 1) ? 1 : cols - sweep_col;
      total    = (sweep_row >= rows - 1) ? row_rest : row_rest + (rows - 1 - sweep_row) * cols;
      queue_cells(total);
      wait_idle();
   endtask

   initial begin
      logic [CELL_W-1:0] probe_grid [24];
      sweep_kind_type    kind;
      int                pick;
      int                cols;
      int                depth;
      int                part;
      probe_grid = '{
         16'd0,     16'd65535, 16'd0,   16'd65535, 16'd0,     16'd65535,
         16'd65535, 16'd1,     16'd200, 16'd2,     16'd100,   16'd65535,
         16'd32768, 16'd200,   16'd0,   16'd100,   16'd65535, 16'd100,
         16'd0,     16'd65535, 16'd300, 16'd43690, 16'd100,   16'd21845
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_count(CSR_COLUMN_COUNT, 6);
      write_count(CSR_ROW_COUNT, 4);
      write_reg(CSR_DOSE, 15'h4000);
      @(negedge clock);
      foreach (probe_grid[i]) old_cells_to_send.push_back(probe_grid[i]);
      wait_idle();

      cells_queued = 0;
      while (cells_queued < RANDOM_CELLS) begin
         pick = $urandom_range(0, 9);
         kind = (pick < 7) ? SWEEP_PLAIN : (pick < 9) ? SWEEP_ROWS_CUT : SWEEP_COLS_CUT;
         case (kind)
            SWEEP_PLAIN: begin
               write_count(CSR_COLUMN_COUNT, ($urandom_range(0, 9) == 0) ?
                           $urandom_range(0, 2) : $urandom_range(3, 12));
               write_count(CSR_ROW_COUNT, ($urandom_range(0, 9) == 0) ?
                           $urandom_range(0, 2) : $urandom_range(3, 8));
               if ($urandom_range(0, 4) != 0) write_reg(CSR_DOSE, pick_dose());
               finish_sweep();
            end
            SWEEP_ROWS_CUT: begin
               write_count(CSR_COLUMN_COUNT, $urandom_range(0, 8));
               write_count(CSR_ROW_COUNT, $urandom_range(1024, 2047));
               write_reg(CSR_DOSE, pick_dose());
               cols  = clamp_count(cols_setting, GRID_MAX);
               depth = $urandom_range(3, 6);
               part  = $urandom_range(0, cols - 1);
               queue_cells(depth * cols + part);
               wait_idle();
               write_count(CSR_ROW_COUNT, $urandom_range(0, depth + 1));
               if ($urandom_range(0, 1) == 0)
                  write_count(CSR_COLUMN_COUNT, $urandom_range(0, cols));
               if ($urandom_range(0, 1) == 0) write_reg(CSR_DOSE, pick_dose());
               finish_sweep();
            end
            default: begin
               write_count(CSR_COLUMN_COUNT, $urandom_range(1024, 2047));
               write_count(CSR_ROW_COUNT, $urandom_range(0, 5));
               write_reg(CSR_DOSE, pick_dose());
               queue_cells($urandom_range(4, 30));
               wait_idle();
               write_count(CSR_COLUMN_COUNT, $urandom_range(0, 10));
               finish_sweep();
            end
         endcase
      end

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
hdl/gsds_pkg.sv
hdl/gsds_ram.sv
hdl/gsds_front.sv
hdl/gsds_stencil.sv
hdl/gsds_accum.sv
hdl/gsds_out_queue.sv
hdl/grid_stencil_dose_sweep_top.sv
bench/grid_stencil_dose_sweep_top_tb.sv
